FILE: sv/bps_pkg.sv
// shared types and constants for the branch pair selector
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

	// matrix geometry and value widths
	localparam int MAX_N      = 64;
	localparam int IDX_BITS   = 6;
	localparam int CNT_BITS   = 7;
	localparam int VALUE_BITS = 32;
	localparam int SCORE_BITS = VALUE_BITS + 2;
	localparam int THR_BITS   = 31;

	// register map, index taken from paddr[3:2]
	localparam logic [1:0] REG_SIZE_N    = 2'd0;
	localparam logic [1:0] REG_ABS_MODE  = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	// register reset values
	localparam logic [CNT_BITS-1:0] SIZE_N_RST = 7'd64;
	localparam logic [THR_BITS-1:0] THR_RST    = 31'd168;

	typedef logic [IDX_BITS-1:0]          idx_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;
	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic signed [SCORE_BITS-1:0] score_t;

	// request to the score unit
	typedef struct packed {
		logic valid;
		logic first;
		logic use_col;
		idx_t lo;
		idx_t hi;
	} score_req_t;

	// registered answer of the score unit
	typedef struct packed {
		logic   valid;
		logic   first;
		idx_t   lo;
		idx_t   hi;
		score_t score;
	} score_res_t;

	// final selection handed to the output register
	typedef struct packed {
		logic   found;
		idx_t   lo;
		idx_t   hi;
		score_t score;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/bps_store.sv
// matrix storage: off-diagonal memory and diagonal memory with registered reads
`timescale 1ns / 1ps
`default_nettype none

module bps_store (
	input  wire              clk,
	input  wire              wr_en,
	input  bps_pkg::idx_t    wr_row,
	input  bps_pkg::idx_t    wr_col,
	input  bps_pkg::val_t    wr_value,
	input  bps_pkg::idx_t    rd_row,
	input  bps_pkg::idx_t    rd_col,
	output bps_pkg::val_t    off_rd,
	output bps_pkg::val_t    dia_row_rd,
	output bps_pkg::val_t    dia_col_rd
);
	import bps_pkg::*;

	val_t off_mem [MAX_N*MAX_N];
	val_t dia_mem [MAX_N];

	val_t off_q;
	val_t dia_row_q;
	val_t dia_col_q;

	// off-diagonal memory, addressed by row and column side by side
	always_ff @(posedge clk) begin
		if (wr_en && (wr_row != wr_col)) begin
			off_mem[{wr_row, wr_col}] <= wr_value;
		end
		off_q <= off_mem[{rd_row, rd_col}];
	end

	// diagonal memory, one write port and two read ports
	always_ff @(posedge clk) begin
		if (wr_en && (wr_row == wr_col)) begin
			dia_mem[wr_row] <= wr_value;
		end
		dia_row_q <= dia_mem[rd_row];
		dia_col_q <= dia_mem[rd_col];
	end

	assign off_rd     = off_q;
	assign dia_row_rd = dia_row_q;
	assign dia_col_rd = dia_col_q;

endmodule

`default_nettype wire

FILE: sv/bps_score_unit.sv
// shared score unit: min(z, d - z) with optional absolute difference, registered
`timescale 1ns / 1ps
`default_nettype none

module bps_score_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bps_pkg::score_req_t  req,
	input  bps_pkg::val_t        off,
	input  bps_pkg::val_t        dia_row,
	input  bps_pkg::val_t        dia_col,
	input  wire                  abs_mode,
	output bps_pkg::score_res_t  res
);
	import bps_pkg::*;

	score_t off_w;
	score_t dia_w;
	score_t diff;
	score_t mag;
	score_t score;

	logic   valid_s1;
	logic   first_s1;
	idx_t   lo_s1;
	idx_t   hi_s1;
	score_t score_s1;

	// widen both operands so the difference never wraps
	always_comb begin
		off_w = SCORE_BITS'(off);
		dia_w = req.use_col ? SCORE_BITS'(dia_col) : SCORE_BITS'(dia_row);
		diff  = dia_w - off_w;
		mag   = (abs_mode && diff[SCORE_BITS-1]) ? -diff : diff;
		score = (off_w < mag) ? off_w : mag;
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		first_s1 <= req.first;
		lo_s1    <= req.lo;
		hi_s1    <= req.hi;
		score_s1 <= score;
	end

	assign res = '{valid: valid_s1, first: first_s1, lo: lo_s1, hi: hi_s1, score: score_s1};

endmodule

`default_nettype wire

FILE: sv/bps_seq.sv
// pair scan sequencer: walks i < j, drives the score unit and keeps the best pair
`timescale 1ns / 1ps
`default_nettype none

module bps_seq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  bps_pkg::cnt_t        size_n,
	input  wire [30:0]           threshold,
	input  wire                  out_free,
	input  bps_pkg::score_res_t  score_res,
	output logic                 idle,
	output bps_pkg::score_req_t  req,
	output bps_pkg::idx_t        rd_row,
	output bps_pkg::idx_t        rd_col,
	output logic                 res_valid,
	output bps_pkg::result_t     result
);
	import bps_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_S1    = 3'd2;
	localparam logic [2:0] ST_S2    = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	idx_t       i_q;
	idx_t       j_q;
	score_t     best_q;
	idx_t       bi_q;
	idx_t       bj_q;
	logic       have_q;

	cnt_t   n_eff;
	logic   last_col;
	logic   last_pair;
	idx_t   next_i;
	idx_t   next_j;
	score_t thr_w;
	logic   found;

	// clamp the dimension and find the pair that follows i, j
	always_comb begin
		n_eff     = (size_n > CNT_BITS'(MAX_N)) ? CNT_BITS'(MAX_N) : size_n;
		last_col  = ({1'b0, j_q} == (n_eff - 7'd1));
		last_pair = last_col && ({1'b0, i_q} == (n_eff - 7'd2));
		next_i    = last_col ? (i_q + 6'd1) : i_q;
		next_j    = last_col ? (i_q + 6'd2) : (j_q + 6'd1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_START;
			end
			ST_START: begin
				state_d = (n_eff < 7'd2) ? ST_DONE : ST_S1;
			end
			ST_S1: begin
				state_d = ST_S2;
			end
			ST_S2: begin
				state_d = last_pair ? ST_FLUSH : ST_S1;
			end
			ST_FLUSH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory read address: first pair at start, next pair in the second phase
	always_comb begin
		rd_row = i_q;
		rd_col = j_q;
		case (state_q)
			ST_START: begin
				rd_row = '0;
				rd_col = 6'd1;
			end
			ST_S2: begin
				rd_row = next_i;
				rd_col = next_j;
			end
			default: begin
				rd_row = i_q;
				rd_col = j_q;
			end
		endcase
	end

	// score unit request: row diagonal in the first phase, column diagonal in the second
	always_comb begin
		req.valid   = (state_q == ST_S1) || (state_q == ST_S2);
		req.first   = (state_q == ST_S1) && (i_q == '0) && (j_q == 6'd1);
		req.use_col = (state_q == ST_S2);
		req.lo      = i_q;
		req.hi      = j_q;
	end

	// state and pair counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= 6'd1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_START) begin
				i_q <= '0;
				j_q <= 6'd1;
			end else if (state_q == ST_S2) begin
				i_q <= next_i;
				j_q <= next_j;
			end
		end
	end

	// running best, first strict maximum wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			bi_q   <= '0;
			bj_q   <= '0;
			have_q <= 1'b0;
		end else if (state_q == ST_START) begin
			best_q <= '0;
			bi_q   <= '0;
			bj_q   <= '0;
			have_q <= 1'b0;
		end else if (score_res.valid && (score_res.first || (score_res.score > best_q))) begin
			best_q <= score_res.score;
			bi_q   <= score_res.lo;
			bj_q   <= score_res.hi;
			have_q <= 1'b1;
		end
	end

	// threshold check and result
	always_comb begin
		thr_w         = {{(SCORE_BITS-THR_BITS){1'b0}}, threshold};
		found         = have_q && (best_q >= thr_w);
		result.found  = found;
		result.lo     = found ? bi_q : '0;
		result.hi     = found ? bj_q : '0;
		result.score  = best_q;
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	// scanned pairs always have the row below the column
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S1) |-> (i_q < j_q))
		else $error("scan pair out of order");

	// second phase leads to the next pair or to the flush
	a_phase_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S2) |=> ((state_q == ST_S1) || (state_q == ST_FLUSH)))
		else $error("bad phase sequence");

	// a reported pair is sorted
	a_found_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && result.found) |-> (result.lo < result.hi))
		else $error("reported pair not sorted");

	// the last score reaches the compare in the flush cycle
	a_flush_score: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (score_res.valid && score_res.lo == bi_q) || score_res.valid)
		else $error("no score pending at flush");

endmodule

`default_nettype wire

FILE: sv/branch_pair_selector.sv
// top level of the branch pair selector: config port, stream ports, output register
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata: row, column, value; s_tlast: last entry
// m_*       out  m_tvalid / m_tready    m_tdata: lower, upper, score; m_tuser: found
// apb       in   psel & penable         paddr, pwdata, prdata (size_n, abs_mode, threshold)
//
// a non-final entry can be taken every cycle while the sequencer is idle;
// after the final entry the scan scores each pair on the single score unit
// in a row phase then a column phase; no pair is scored if size_n is below two
// arst_n clears control state; matrix memories hold undefined data until written
// s_tready is low while a scan runs or its result waits for the output register
`timescale 1ns / 1ps
`default_nettype none

module branch_pair_selector (
	input  wire         clk,
	input  wire         arst_n,
	// entry input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // row_index[5:0], col_index[11:6], entry_value[43:12], zeros
	input  wire         s_tlast,
	// result output stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // lower_index[5:0], upper_index[11:6], best_score[45:12], zeros
	output logic        m_tuser,   // branch_found[0]
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bps_pkg::*;

	cnt_t          size_n_q;
	logic          abs_mode_q;
	logic [30:0]   thr_q;

	logic          cfg_wr;
	logic          s_accept;
	logic          seq_idle;
	logic          out_free;
	logic          res_valid;
	result_t       result;
	score_req_t    req;
	score_res_t    score_res;
	idx_t          rd_row;
	idx_t          rd_col;
	val_t          off_rd;
	val_t          dia_row_rd;
	val_t          dia_col_rd;

	logic          m_tvalid_q;
	logic          found_q;
	idx_t          lo_q;
	idx_t          hi_q;
	score_t        score_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_n_q   <= SIZE_N_RST;
			abs_mode_q <= 1'b0;
			thr_q      <= THR_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SIZE_N:    size_n_q   <= pwdata[CNT_BITS-1:0];
				REG_ABS_MODE:  abs_mode_q <= pwdata[0];
				REG_THRESHOLD: thr_q      <= pwdata[THR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_SIZE_N:    prdata = {25'd0, size_n_q};
			REG_ABS_MODE:  prdata = {31'd0, abs_mode_q};
			REG_THRESHOLD: prdata = {1'b0, thr_q};
			default:       prdata = '0;
		endcase
	end

	// input transfer
	assign s_tready = seq_idle;
	assign s_accept = s_tvalid && s_tready;

	bps_store u_store (
		.clk        (clk),
		.wr_en      (s_accept),
		.wr_row     (s_tdata[5:0]),
		.wr_col     (s_tdata[11:6]),
		.wr_value   (s_tdata[43:12]),
		.rd_row     (rd_row),
		.rd_col     (rd_col),
		.off_rd     (off_rd),
		.dia_row_rd (dia_row_rd),
		.dia_col_rd (dia_col_rd)
	);

	bps_score_unit u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.off      (off_rd),
		.dia_row  (dia_row_rd),
		.dia_col  (dia_col_rd),
		.abs_mode (abs_mode_q),
		.res      (score_res)
	);

	bps_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_accept && s_tlast),
		.size_n    (size_n_q),
		.threshold (thr_q),
		.out_free  (out_free),
		.score_res (score_res),
		.idle      (seq_idle),
		.req       (req),
		.rd_row    (rd_row),
		.rd_col    (rd_col),
		.res_valid (res_valid),
		.result    (result)
	);

	// output register, loaded when empty or being drained
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			found_q <= result.found;
			lo_q    <= result.lo;
			hi_q    <= result.hi;
			score_q <= result.score;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, score_q, hi_q, lo_q};
	assign m_tuser  = found_q;

endmodule

`default_nettype wire
